/* rtl/ptrc_pkg.sv */
// Shared constants, types and helpers for the timed relay channel block.
package ptrc_pkg;

  localparam int unsigned RELAY_MAX   = 8;
  localparam int unsigned MASK_W      = 8;
  localparam int unsigned CODE_W      = 32;
  localparam int unsigned DLY_W       = 16;
  localparam int unsigned LVL_W       = 3;
  localparam int unsigned CH_W        = 4;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [LVL_W-1:0]  PLATFORM_LEVEL = 3'd2;

  localparam logic [CODE_W-1:0] CODE_OFF      = 32'h0000_0000;
  localparam logic [CODE_W-1:0] CODE_ONE      = 32'h0000_0001;
  localparam logic [CODE_W-1:0] CODE_KEEP_ON  = 32'hFFFF_FFFF;
  localparam logic [CODE_W-1:0] CODE_KEEP_OFF = 32'hFFFF_FFFE;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_CH  = 2'd1;
  localparam logic [STAT_W-1:0] ST_LOW_LVL = 2'd2;

  localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_KEEP_ON  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_KEEP_OFF = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TIMED    = 2'd3;

  localparam logic [CODE_W-1:0] SAFE_LIMIT_RST = 32'hFFFF_FFFF;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture the input transaction, restart the sweep
    logic tick_step;  // serve the channel under the sweep pointer
    logic write_en;   // apply the captured write command
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last; // sweep pointer sits on the last channel
  } dp_sts_t;

  function automatic logic [MODE_W-1:0] code_mode(input logic [CODE_W-1:0] code);
    logic [MODE_W-1:0] m;
    if (code == CODE_KEEP_ON) begin
      m = MODE_KEEP_ON;
    end else if (code == CODE_KEEP_OFF) begin
      m = MODE_KEEP_OFF;
    end else if (code != CODE_OFF) begin
      m = MODE_TIMED;
    end else begin
      m = MODE_NONE;
    end
    return m;
  endfunction

endpackage

/* rtl/ptrc_if.sv */
// Valid/ready channel interfaces for command transactions and result transactions.
interface ptrc_req_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [ptrc_pkg::LVL_W-1:0]     priority_level;
  logic [ptrc_pkg::CH_W-1:0]      channel_index;
  logic [ptrc_pkg::CODE_W-1:0]    on_time_code;
  logic [ptrc_pkg::DLY_W-1:0]     delay_ticks;

  modport source (output valid, operation, priority_level, channel_index, on_time_code,
                  delay_ticks, input ready);
  modport sink   (input valid, operation, priority_level, channel_index, on_time_code,
                  delay_ticks, output ready);
endinterface

interface ptrc_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [ptrc_pkg::STAT_W-1:0]    status;
  logic [ptrc_pkg::MASK_W-1:0]    drive_mask;
  logic [ptrc_pkg::MASK_W-1:0]    active_mask;
  logic [ptrc_pkg::MASK_W-1:0]    expiring_mask;
  logic [ptrc_pkg::MODE_W-1:0]    platform_mode;

  modport source (output valid, status, drive_mask, active_mask, expiring_mask,
                  platform_mode, input ready);
  modport sink   (input valid, status, drive_mask, active_mask, expiring_mask,
                  platform_mode, output ready);
endinterface

/* rtl/ptrc_ctrl.sv */
// Control state machine: accepts a transaction, sequences the tick sweep or write, holds the result.
module ptrc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_op_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ptrc_pkg::dp_cmd_t  cmd_o,
  input  ptrc_pkg::dp_sts_t  sts_i
);
  import ptrc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_TICK  = 4'b0010,
    S_WRITE = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_RESP);
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.load      = accept;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = in_op_i ? S_WRITE : S_TICK;
        end
      end
      S_TICK: begin
        cmd_o.tick_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_RESP;
        end
      end
      S_WRITE: begin
        cmd_o.write_en = 1'b1;
        state_d        = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/ptrc_dp.sv */
// Datapath: per-channel counters, owners, modes, safety limits and the result registers.
module ptrc_dp #(
  parameter int unsigned CHANNELS = ptrc_pkg::RELAY_MAX
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ptrc_pkg::dp_cmd_t               cmd_i,
  output ptrc_pkg::dp_sts_t               sts_o,
  input  logic [ptrc_pkg::LVL_W-1:0]      level_i,
  input  logic [ptrc_pkg::CH_W-1:0]       channel_i,
  input  logic [ptrc_pkg::CODE_W-1:0]     code_i,
  input  logic [ptrc_pkg::DLY_W-1:0]      delay_i,
  input  logic                            cfg_we_i,
  input  logic [ptrc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ptrc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [ptrc_pkg::STAT_W-1:0]     status_o,
  output logic [ptrc_pkg::MASK_W-1:0]     drive_mask_o,
  output logic [ptrc_pkg::MASK_W-1:0]     active_mask_o,
  output logic [ptrc_pkg::MASK_W-1:0]     expiring_mask_o,
  output logic [ptrc_pkg::MODE_W-1:0]     platform_mode_o
);
  import ptrc_pkg::*;

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);
  localparam logic [CH_W-1:0]  CH_LIMIT = CH_W'(CHANNELS);

  // Captured transaction
  logic [LVL_W-1:0]  lvl_q;
  logic [CH_W-1:0]   ch_q;
  logic [CODE_W-1:0] code_q;
  logic [DLY_W-1:0]  dly_in_q;

  // Channel state
  logic [CODE_W-1:0] cnt_q   [CHANNELS];
  logic [DLY_W-1:0]  dly_q   [CHANNELS];
  logic [LVL_W-1:0]  own_q   [CHANNELS];
  logic [MODE_W-1:0] mode_q  [CHANNELS];
  logic [CODE_W-1:0] lim_q   [CHANNELS];
  logic [CHANNELS-1:0] drive_q;
  logic [CHANNELS-1:0] active_q;

  // Result
  logic [STAT_W-1:0]   status_q;
  logic [MODE_W-1:0]   rmode_q;
  logic [CHANNELS-1:0] exp_q;

  logic [IDX_W-1:0] idx_q;

  // Tick path for the channel under the sweep pointer
  logic [CODE_W-1:0] cur_cnt, cur_lim, clamped, nxt_cnt;
  logic [DLY_W-1:0]  cur_dly, nxt_dly;
  logic              nxt_drive, nxt_act, nxt_exp, own_clr;

  // Write path
  logic [IDX_W-1:0]  wsel;
  logic              ch_ok, lvl_low;
  logic [MODE_W-1:0] wmode;

  assign cur_cnt = cnt_q[idx_q];
  assign cur_dly = dly_q[idx_q];
  assign cur_lim = lim_q[idx_q];
  assign clamped = (cur_cnt > cur_lim) ? cur_lim : cur_cnt;

  always_comb begin
    nxt_cnt   = cur_cnt;
    nxt_dly   = cur_dly;
    nxt_drive = drive_q[idx_q];
    own_clr   = 1'b0;
    if (cur_dly != '0) begin
      nxt_dly = cur_dly - 1'b1;
    end else begin
      nxt_cnt = clamped;
      if (clamped == CODE_OFF) begin
        nxt_drive = 1'b0;
        own_clr   = 1'b1;
      end else if (clamped == CODE_KEEP_ON) begin
        nxt_drive = 1'b1;
      end else if (clamped == CODE_KEEP_OFF) begin
        nxt_drive = 1'b0;
      end else begin
        nxt_drive = 1'b1;
        nxt_cnt   = clamped - 1'b1;
      end
    end
    nxt_act = (nxt_cnt != CODE_OFF) && (nxt_cnt != CODE_KEEP_OFF);
    nxt_exp = nxt_act && (nxt_cnt == CODE_ONE);
  end

  assign wsel    = ch_q[IDX_W-1:0];
  assign ch_ok   = ch_q < CH_LIMIT;
  assign lvl_low = lvl_q < own_q[wsel];
  assign wmode   = (lvl_q == PLATFORM_LEVEL) ? code_mode(code_q) : mode_q[wsel];

  assign sts_o.sweep_last = (idx_q == LAST_IDX);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lvl_q    <= level_i;
      ch_q     <= channel_i;
      code_q   <= code_i;
      dly_in_q <= delay_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cnt_q[i]  <= CODE_OFF;
        dly_q[i]  <= '0;
        own_q[i]  <= '0;
        mode_q[i] <= MODE_NONE;
        lim_q[i]  <= SAFE_LIMIT_RST;
      end
      drive_q  <= '0;
      active_q <= '0;
      status_q <= ST_OK;
      rmode_q  <= MODE_NONE;
      exp_q    <= '0;
      idx_q    <= '0;
    end else begin
      if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(CHANNELS))) begin
        lim_q[cfg_idx_i[IDX_W-1:0]] <= cfg_data_i;
      end
      if (cmd_i.load) begin
        idx_q    <= '0;
        exp_q    <= '0;
        status_q <= ST_OK;
        rmode_q  <= MODE_NONE;
      end
      if (cmd_i.tick_step) begin
        cnt_q[idx_q]    <= nxt_cnt;
        dly_q[idx_q]    <= nxt_dly;
        drive_q[idx_q]  <= nxt_drive;
        active_q[idx_q] <= nxt_act;
        exp_q[idx_q]    <= nxt_exp;
        if (own_clr) begin
          own_q[idx_q] <= '0;
        end
        if (nxt_exp) begin
          mode_q[idx_q] <= MODE_NONE;
        end
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.write_en) begin
        if (!ch_ok) begin
          status_q <= ST_BAD_CH;
          rmode_q  <= MODE_NONE;
        end else if (lvl_low) begin
          status_q <= ST_LOW_LVL;
          rmode_q  <= mode_q[wsel];
        end else begin
          status_q       <= ST_OK;
          rmode_q        <= wmode;
          mode_q[wsel]   <= wmode;
          own_q[wsel]    <= lvl_q;
          cnt_q[wsel]    <= code_q;
          dly_q[wsel]    <= dly_in_q;
          active_q[wsel] <= (code_q != CODE_OFF) && (code_q != CODE_KEEP_OFF);
        end
      end
    end
  end

  assign status_o        = status_q;
  assign platform_mode_o = rmode_q;
  assign drive_mask_o    = MASK_W'(drive_q);
  assign active_mask_o   = MASK_W'(active_q);
  assign expiring_mask_o = MASK_W'(exp_q);

endmodule

/* rtl/prioritized_timed_relay_channels.sv */
// A tick is accepted in IDLE, sweeps the channels in TICK and holds its result in RESP; a write
// is accepted in IDLE, applied in WRITE and held in RESP. The tick sweep serves one channel per
// cycle through a single counter/limit unit.
// The next transaction is accepted once the held result has been taken.
// Reset: asynchronous, active low; counters, owners, modes and drive bits clear, safety
// limits return to all ones. No clearing pass is needed.
module prioritized_timed_relay_channels #(
  parameter int unsigned CHANNELS = ptrc_pkg::RELAY_MAX
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ptrc_req_if.sink                        req_i,
  ptrc_rsp_if.source                      rsp_o,
  input  logic                            cfg_we_i,
  input  logic [ptrc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ptrc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ptrc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ptrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_op_i     (req_i.operation),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ptrc_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .level_i         (req_i.priority_level),
    .channel_i       (req_i.channel_index),
    .code_i          (req_i.on_time_code),
    .delay_i         (req_i.delay_ticks),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .status_o        (rsp_o.status),
    .drive_mask_o    (rsp_o.drive_mask),
    .active_mask_o   (rsp_o.active_mask),
    .expiring_mask_o (rsp_o.expiring_mask),
    .platform_mode_o (rsp_o.platform_mode)
  );

  // Never take a new transaction while a result is held
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rsp_o.valid && req_i.ready))
    else $error("input ready while result pending");

  // A result never appears in the cycle right after acceptance
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !rsp_o.valid)
    else $error("result too early");

  // Only a tick reports expiring channels; a refused write must show none
  a_exp_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != ST_OK)) |-> (rsp_o.expiring_mask == '0))
    else $error("expiring mask on refused write");

  // Expiring channels are a subset of active channels
  a_exp_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> ((rsp_o.expiring_mask & ~rsp_o.active_mask) == '0))
    else $error("expiring channel not active");

endmodule
